>>> design/huffman_tree_walk_decoder_assert.svh
// Assertion macros for the tree-walk decoder.
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HTWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/htwd_pkg.sv
// Shared constants for the tree-walk decoder.
package htwd_pkg;

    localparam int NODE_COUNT_DEF = 512;

    localparam int BYTE_BITS   = 8;
    localparam int COUNT_W     = 4;
    localparam int IDX_IN_W    = 9;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_LABEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd2;

endpackage

>>> design/huffman_tree_walk_decoder.sv
// Label write on acceptance; an edge reads the node's left slot, then writes the child.
// Throughput: one item at a time; a data byte walks one tree level per cycle through the
// registered child memories, but a leaf hit before a bit waits for the output to be free
// and then restarts the walk with a root read before the bit is taken.
// Reset: i_rst_n synchronous active low; afterwards a clearing pass over all NODE_COUNT
// nodes zeroes the child memories while the input is held off. Labels are not cleared.
module huffman_tree_walk_decoder
    import htwd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // node_index[8:0], child_index[17:9], label[25:18], data_byte[33:26],
    // bit_count[37:34], zero pad[39:38]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]      i_s_axis_tuser,
    // final_req
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // symbol[7:0]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // last_of_run
    output logic                   o_m_axis_tlast
);

    localparam int AW = $clog2(NODE_COUNT);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EDGE  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    // input fields
    logic [IDX_IN_W-1:0]  in_node;
    logic [IDX_IN_W-1:0]  in_child;
    logic [BYTE_BITS-1:0] in_label;
    logic [BYTE_BITS-1:0] in_data;
    logic [COUNT_W-1:0]   in_count;
    logic                 in_node_ok;
    logic                 in_child_ok;

    assign in_node  = i_s_axis_tdata[8:0];
    assign in_child = i_s_axis_tdata[17:9];
    assign in_label = i_s_axis_tdata[25:18];
    assign in_data  = i_s_axis_tdata[33:26];
    assign in_count = i_s_axis_tdata[37:34];
    assign in_node_ok  = int'(in_node) < NODE_COUNT;
    assign in_child_ok = int'(in_child) < NODE_COUNT;

    logic [2:0]           r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_node, n_node;
    logic [AW-1:0]        r_child, n_child;
    logic [BYTE_BITS-1:0] r_data, n_data;
    logic [COUNT_W-1:0]   r_bits, n_bits;
    logic                 r_final, n_final;
    logic                 r_just, n_just;
    logic                 r_pend_v, n_pend_v;
    logic [BYTE_BITS-1:0] r_pend_sym, n_pend_sym;
    logic                 r_out_v, n_out_v;
    logic [BYTE_BITS-1:0] r_out_sym, n_out_sym;
    logic                 r_out_last, n_out_last;

    // memory ports
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        lft_rd, rgt_rd;
    logic [BYTE_BITS-1:0] lab_rd;
    logic                 lab_we;
    logic [AW-1:0]        lab_waddr;
    logic                 lft_we, rgt_we;
    logic [AW-1:0]        ch_waddr;
    logic [AW-1:0]        ch_wdata;

    logic accept;
    logic out_free;
    logic leaf;
    logic can_emit;
    logic [AW-1:0] walk_next;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_v || i_m_axis_tready;
    assign leaf            = (lft_rd == '0) && (rgt_rd == '0);
    assign can_emit        = !r_pend_v || out_free;
    assign walk_next       = r_data[BYTE_BITS-1] ? rgt_rd : lft_rd;
    assign lab_waddr       = AW'(in_node);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_pos      = r_pos;
        n_node     = r_node;
        n_child    = r_child;
        n_data     = r_data;
        n_bits     = r_bits;
        n_final    = r_final;
        n_just     = r_just;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_out_v    = r_out_v && !i_m_axis_tready;
        n_out_sym  = r_out_sym;
        n_out_last = r_out_last;

        rd_addr  = r_pos;
        lab_we   = 1'b0;
        lft_we   = 1'b0;
        rgt_we   = 1'b0;
        ch_waddr = r_node;
        ch_wdata = r_child;

        unique case (r_state)
            ST_CLEAR: begin
                lft_we   = 1'b1;
                rgt_we   = 1'b1;
                ch_waddr = r_clr;
                ch_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tuser == MODE_EDGE) begin
                    rd_addr = AW'(in_node);
                end
                if (accept) begin
                    unique case (i_s_axis_tuser)
                        MODE_LABEL: begin
                            lab_we = in_node_ok;
                        end
                        MODE_EDGE: begin
                            n_node  = AW'(in_node);
                            n_child = AW'(in_child);
                            if (in_node_ok && in_child_ok) begin
                                n_state = ST_EDGE;
                            end
                        end
                        MODE_DATA: begin
                            n_data  = in_data;
                            n_bits  = (in_count > COUNT_W'(BYTE_BITS)) ?
                                      COUNT_W'(BYTE_BITS) : in_count;
                            n_final = i_s_axis_tlast;
                            n_just  = 1'b0;
                            n_state = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                // left slot taken: put the child in the right slot
                if (lft_rd != '0) begin
                    rgt_we = 1'b1;
                end else begin
                    lft_we = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_WALK: begin
                if (r_bits != '0) begin
                    if (leaf && !r_just) begin
                        if (can_emit) begin
                            if (r_pend_v) begin
                                n_out_v    = 1'b1;
                                n_out_sym  = r_pend_sym;
                                n_out_last = 1'b0;
                            end
                            n_pend_v   = 1'b1;
                            n_pend_sym = lab_rd;
                            n_pos      = '0;
                            n_just     = 1'b1;
                            rd_addr    = '0;
                        end
                    end else begin
                        // missing child reads as zero and lands on the root
                        n_pos   = walk_next;
                        rd_addr = walk_next;
                        n_data  = {r_data[BYTE_BITS-2:0], 1'b0};
                        n_bits  = r_bits - 1'b1;
                        n_just  = 1'b0;
                    end
                end else if (leaf && r_final) begin
                    if (can_emit) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_sym  = r_pend_sym;
                            n_out_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_sym = lab_rd;
                        n_pos      = '0;
                        rd_addr    = '0;
                        n_state    = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_sym  = r_pend_sym;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_pos    <= '0;
            r_just   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pos    <= n_pos;
            r_just   <= n_just;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_child    <= n_child;
        r_data     <= n_data;
        r_bits     <= n_bits;
        r_final    <= n_final;
        r_pend_sym <= n_pend_sym;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    htwd_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_labels (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_waddr (lab_waddr),
        .i_wdata (in_label),
        .i_raddr (rd_addr),
        .o_rdata (lab_rd)
    );

    htwd_ram #(
        .WIDTH (AW),
        .DEPTH (NODE_COUNT)
    ) u_left (
        .i_clk   (i_clk),
        .i_we    (lft_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wdata),
        .i_raddr (rd_addr),
        .o_rdata (lft_rd)
    );

    htwd_ram #(
        .WIDTH (AW),
        .DEPTH (NODE_COUNT)
    ) u_right (
        .i_clk   (i_clk),
        .i_we    (rgt_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rgt_rd)
    );

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_sym;
    assign o_m_axis_tlast  = r_out_last;

`include "huffman_tree_walk_decoder_assert.svh"

    `HTWD_ASSERT_NOW(a_idle_no_pending, r_state == ST_IDLE, !r_pend_v, "symbol left pending in idle")
    `HTWD_ASSERT_NOW(a_pos_in_range, 1'b1, int'(r_pos) < NODE_COUNT, "walk position out of range")
    `HTWD_ASSERT_NEXT(a_data_walks, accept && i_s_axis_tuser == MODE_DATA, r_state == ST_WALK, "data transaction did not start a walk")
    `HTWD_ASSERT_NOW(a_bits_bound, r_state == ST_WALK, r_bits <= COUNT_W'(BYTE_BITS), "bit count above a byte")

endmodule

>>> design/htwd_ram.sv
// Generic simple dual-port RAM with registered read.
module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
